@@ rtl/core/assert_macros.svh @@
// assertion helpers for the rtl files
// both macros expect clk in scope; LRS_ASSERT also expects rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// checked only outside reset
`define LRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define LRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LRS_ASSERT(lbl, prop, msg)
`define LRS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/core/lrs_pkg.sv @@
`timescale 1ns / 1ps

package lrs_pkg;

  // timer width
  localparam int CNT_W = 8;

  // field widths
  localparam int REQ_W   = 3;
  localparam int STATE_W = 3;
  localparam int REG_W   = 8;
  localparam int CFG_A_W = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_TICK      = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CONNECTED = 3'd1;
  localparam logic [REQ_W-1:0] REQ_GOT_IP    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DISCONN   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CONNECT   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SET_AP    = 3'd5;
  localparam logic [REQ_W-1:0] REQ_CLR_AP    = 3'd6;
  localparam logic [REQ_W-1:0] REQ_INIT      = 3'd7;

  // link states
  localparam logic [STATE_W-1:0] ST_IDLE      = 3'd0;
  localparam logic [STATE_W-1:0] ST_AP_ONLY   = 3'd1;
  localparam logic [STATE_W-1:0] ST_GRACE_EN  = 3'd2;
  localparam logic [STATE_W-1:0] ST_GRACE_DIS = 3'd3;
  localparam logic [STATE_W-1:0] ST_RECONN    = 3'd4;
  localparam logic [STATE_W-1:0] ST_COOLDOWN  = 3'd5;
  localparam logic [STATE_W-1:0] ST_NO_IP     = 3'd6;
  localparam logic [STATE_W-1:0] ST_GOOD      = 3'd7;

  // register indexes
  localparam logic [CFG_A_W-1:0] CFG_AP_GRACE     = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_STA_CONNECT  = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_STA_COOLDOWN = 2'd2;
  localparam logic [CFG_A_W-1:0] CFG_START_AP     = 2'd3;

  // register reset values
  localparam logic [REG_W-1:0] AP_GRACE_RST     = 8'd15;
  localparam logic [REG_W-1:0] STA_CONNECT_RST  = 8'd10;
  localparam logic [REG_W-1:0] STA_COOLDOWN_RST = 8'd90;

  // input word
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             ap_active;
    logic             sta_active;
  } lrs_req_t;

  // command strobes of one result
  typedef struct packed {
    logic ap_start;
    logic ap_stop;
    logic sta_disable;
    logic sta_begin;
    logic mdns_start;
    logic ticks_on;
  } lrs_cmd_t;

endpackage

@@ rtl/core/lrs_if.sv @@
`timescale 1ns / 1ps

// event channel
interface lrs_in_if import lrs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic             ap_active;
  logic             sta_active;

  modport source (output valid, output req_type, output ap_active, output sta_active,
                  input ready);
  modport sink (input valid, input req_type, input ap_active, input sta_active,
                output ready);
endinterface

// result channel
interface lrs_out_if import lrs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STATE_W-1:0] link_state;
  logic               ap_start;
  logic               ap_stop;
  logic               sta_disable;
  logic               sta_begin;
  logic               mdns_start;
  logic               ticks_on;

  modport source (output valid, output link_state, output ap_start, output ap_stop,
                  output sta_disable, output sta_begin, output mdns_start,
                  output ticks_on, input ready);
  modport sink (input valid, input link_state, input ap_start, input ap_stop,
                input sta_disable, input sta_begin, input mdns_start,
                input ticks_on, output ready);
endinterface

@@ rtl/core/link_reconnect_supervisor_unit.sv @@
`timescale 1ns / 1ps

// Link reconnect supervisor: one event word in, one result word out, in order.
// Each word passes an input register, then the state update and command decode,
// then the result register, which takes the result once the previous result is
// drained, and one event is taken every cycle as long as results are drained. The
// figure is set by the single state-update stage: link mode, grace counter,
// retry counter and tick flag change once per event word, between the two
// registers. Timer limits and the access-point-only start flag are to be written
// by the user on the cfg port while no event is in flight; the block does not enforce it.
`include "assert_macros.svh"

module link_reconnect_supervisor_unit import lrs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  lrs_in_if.sink             in_ch,
  lrs_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_index,
  input  logic [REG_W-1:0]   cfg_wdata
);

  // configuration registers
  logic [REG_W-1:0] ap_grace_r;
  logic [REG_W-1:0] sta_connect_r;
  logic [REG_W-1:0] sta_cooldown_r;
  logic             start_ap_only_r;

  // supervisor state
  logic [STATE_W-1:0] mode_r, mode_nxt;
  logic [CNT_W-1:0]   ap_cnt_r, ap_cnt_nxt;
  logic [CNT_W-1:0]   sta_cnt_r, sta_cnt_nxt;
  logic               tick_en_r, tick_en_nxt;

  // input stage
  logic     s1_valid_r;
  lrs_req_t s1_r;

  // result stage
  logic               out_valid_r;
  logic [STATE_W-1:0] out_state_r;
  lrs_cmd_t           out_cmd_r;
  lrs_cmd_t           cmd_nxt;

  logic             proc;
  logic             in_take;
  logic [CNT_W-1:0] grace;
  logic [CNT_W-1:0] connect_ld;
  logic [CNT_W-1:0] cooldown_ld;
  logic [CNT_W-1:0] ap_dec;
  logic [CNT_W-1:0] sta_dec;

  // handshake
  assign proc    = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || proc;
  assign in_take = in_ch.valid && in_ch.ready;

  // config write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ap_grace_r      <= AP_GRACE_RST;
      sta_connect_r   <= STA_CONNECT_RST;
      sta_cooldown_r  <= STA_COOLDOWN_RST;
      start_ap_only_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AP_GRACE:     ap_grace_r      <= cfg_wdata;
        CFG_STA_CONNECT:  sta_connect_r   <= cfg_wdata;
        CFG_STA_COOLDOWN: sta_cooldown_r  <= cfg_wdata;
        CFG_START_AP:     start_ap_only_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // timer loads, cut or padded to the counter width
  assign grace       = CNT_W'(ap_grace_r);
  assign connect_ld  = CNT_W'(sta_connect_r);
  assign cooldown_ld = CNT_W'(sta_cooldown_r);
  assign ap_dec      = ap_cnt_r - CNT_W'(1);
  assign sta_dec     = sta_cnt_r - CNT_W'(1);

  // state update and command decode
  always_comb begin
    mode_nxt    = mode_r;
    ap_cnt_nxt  = ap_cnt_r;
    sta_cnt_nxt = sta_cnt_r;
    tick_en_nxt = tick_en_r;
    cmd_nxt     = '0;

    case (s1_r.req_type)
      REQ_TICK: begin
        if (tick_en_r) begin
          unique case (mode_r)
            ST_AP_ONLY: begin
              cmd_nxt.ap_start    = !s1_r.ap_active;
              cmd_nxt.sta_disable = 1'b1;
              tick_en_nxt         = 1'b0;
            end
            ST_GRACE_DIS: begin
              if (ap_cnt_r != '0) begin
                ap_cnt_nxt = ap_dec;
                if (ap_dec == '0 && s1_r.sta_active) begin
                  cmd_nxt.ap_stop = 1'b1;
                  mode_nxt        = ST_GOOD;
                  ap_cnt_nxt      = grace;
                end
              end
            end
            ST_GRACE_EN: begin
              if (ap_cnt_r != '0) begin
                ap_cnt_nxt = ap_dec;
                if (ap_dec == '0 && !s1_r.ap_active) begin
                  cmd_nxt.ap_start = 1'b1;
                  mode_nxt         = ST_RECONN;
                  sta_cnt_nxt      = connect_ld;
                end
              end
            end
            ST_RECONN: begin
              if (sta_cnt_r != '0) begin
                sta_cnt_nxt = sta_dec;
                if (sta_dec == '0) begin
                  cmd_nxt.sta_disable = 1'b1;
                  mode_nxt            = ST_COOLDOWN;
                  sta_cnt_nxt         = cooldown_ld;
                end
              end
            end
            ST_COOLDOWN: begin
              if (sta_cnt_r != '0) begin
                sta_cnt_nxt = sta_dec;
                if (sta_dec == '0) begin
                  cmd_nxt.sta_begin = 1'b1;
                  mode_nxt          = ST_RECONN;
                  sta_cnt_nxt       = connect_ld;
                end
              end
            end
            default: ;
          endcase
        end
      end
      REQ_CONNECTED: mode_nxt = ST_NO_IP;
      REQ_GOT_IP: begin
        // grace count dropped on an address while waiting to raise the ap, unless the ap is active and it reloads
        if (mode_r == ST_GRACE_EN) ap_cnt_nxt = '0;
        if (s1_r.ap_active) begin
          mode_nxt   = ST_GRACE_DIS;
          ap_cnt_nxt = grace;
        end else begin
          mode_nxt = ST_GOOD;
        end
        cmd_nxt.mdns_start = 1'b1;
      end
      REQ_DISCONN: begin
        if (mode_r == ST_GOOD) begin
          mode_nxt   = ST_GRACE_EN;
          ap_cnt_nxt = grace;
        end else begin
          tick_en_nxt = 1'b1;
        end
      end
      REQ_CONNECT: begin
        cmd_nxt.sta_begin = 1'b1;
        mode_nxt          = ST_GRACE_EN;
        ap_cnt_nxt        = grace;
      end
      REQ_SET_AP: begin
        mode_nxt    = ST_AP_ONLY;
        tick_en_nxt = 1'b1;
      end
      REQ_CLR_AP: begin
        if (mode_r != ST_GOOD) begin
          mode_nxt          = ST_GRACE_DIS;
          ap_cnt_nxt        = grace;
          tick_en_nxt       = 1'b1;
          cmd_nxt.sta_begin = 1'b1;
        end
      end
      default: begin
        // init
        if (start_ap_only_r || mode_r == ST_AP_ONLY) begin
          mode_nxt            = ST_AP_ONLY;
          cmd_nxt.ap_start    = 1'b1;
          cmd_nxt.sta_disable = 1'b1;
        end else begin
          mode_nxt          = ST_GRACE_EN;
          ap_cnt_nxt        = grace;
          cmd_nxt.sta_begin = 1'b1;
          tick_en_nxt       = 1'b1;
        end
      end
    endcase

    cmd_nxt.ticks_on = tick_en_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= ST_IDLE;
      ap_cnt_r  <= '0;
      sta_cnt_r <= '0;
      tick_en_r <= 1'b0;
    end else if (proc) begin
      mode_r    <= mode_nxt;
      ap_cnt_r  <= ap_cnt_nxt;
      sta_cnt_r <= sta_cnt_nxt;
      tick_en_r <= tick_en_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r.req_type   <= in_ch.req_type;
      s1_r.ap_active  <= in_ch.ap_active;
      s1_r.sta_active <= in_ch.sta_active;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_state_r <= mode_nxt;
      out_cmd_r   <= cmd_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.link_state  = out_state_r;
  assign out_ch.ap_start    = out_cmd_r.ap_start;
  assign out_ch.ap_stop     = out_cmd_r.ap_stop;
  assign out_ch.sta_disable = out_cmd_r.sta_disable;
  assign out_ch.sta_begin   = out_cmd_r.sta_begin;
  assign out_ch.mdns_start  = out_cmd_r.mdns_start;
  assign out_ch.ticks_on    = out_cmd_r.ticks_on;

  // checks
  `LRS_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> (!out_valid_r && !s1_valid_r), "pipe not empty after reset")
  `LRS_ASSERT(a_ap_cmd_excl, out_valid_r |-> !(out_cmd_r.ap_start && out_cmd_r.ap_stop), "ap start and stop together")
  `LRS_ASSERT(a_tick_off_hold, (proc && s1_r.req_type == REQ_TICK && !tick_en_r) |=> ($stable(mode_r) && $stable(ap_cnt_r) && $stable(sta_cnt_r)), "disabled tick moved state")
  `LRS_ASSERT(a_ticks_flag, proc |=> (out_cmd_r.ticks_on == tick_en_r && out_state_r == mode_r), "result does not match state")

endmodule
